// ----- rtl/core/acs_pkg.sv -----
package acs_pkg;

  // Channel counts: the set always carries four readings, the filter keeps
  // the first ACT_CH of them.
  localparam int NUM_IN   = 4;
  localparam int CHANNELS = 4;
  localparam int ACT_CH   = (CHANNELS < NUM_IN) ? CHANNELS : NUM_IN;
  localparam int CH_W     = 2;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(ACT_CH - 1);

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CURRENT = 3'd0;
  localparam cfg_idx_t CFG_BUS     = 3'd1;
  localparam cfg_idx_t CFG_PLANT   = 3'd2;
  localparam cfg_idx_t CFG_TEMP    = 3'd3;
  localparam cfg_idx_t CFG_ALPHA   = 3'd4;
  localparam cfg_idx_t CFG_LIMIT   = 3'd5;

  localparam logic [63:0] CAL_RESET [NUM_IN] = '{
    64'd72060961158070,
    64'd720575253184512,
    64'd720579546809631,
    64'd7205765413470208
  };
  localparam logic [16:0] ALPHA_RESET = 17'd13107;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [15:0] LIMIT_RESET = 16'd4095;

  localparam logic signed [47:0] S32_MAX_W = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] S32_MIN_W = -48'sh0000_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL_MUL,
    ST_CAL_SUM,
    ST_FLT_SUB,
    ST_FLT_MUL,
    ST_FLT_SUM,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic            capture;
    logic            mul_cal;
    logic            mul_flt;
    logic            cal_sum;
    logic            load_avg;
    logic            flt_sub;
    logic            flt_sum;
    logic            out_load;
    logic [CH_W-1:0] ch;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_ok;
    logic primed;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/acs_ctrl.sv -----
module acs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  acs_pkg::status_t  status,
  output acs_pkg::cmd_t     cmd
);

  acs_pkg::state_t state, state_next;
  logic [acs_pkg::CH_W-1:0] ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acs_pkg::ST_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    cmd        = '0;
    cmd.ch     = ch;
    in_stall   = 1'b1;
    unique case (state)
      acs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          ch_next     = '0;
          state_next  = status.in_ok ? acs_pkg::ST_CAL_MUL : acs_pkg::ST_FINISH;
        end
      end
      acs_pkg::ST_CAL_MUL: begin
        cmd.mul_cal = 1'b1;
        state_next  = acs_pkg::ST_CAL_SUM;
      end
      acs_pkg::ST_CAL_SUM: begin
        cmd.cal_sum = 1'b1;
        if (status.primed) begin
          state_next = acs_pkg::ST_FLT_SUB;
        end else begin
          // first accepted set: load the average directly
          cmd.load_avg = 1'b1;
          if (ch == acs_pkg::LAST_CH) begin
            state_next = acs_pkg::ST_FINISH;
          end else begin
            ch_next    = ch + 1'b1;
            state_next = acs_pkg::ST_CAL_MUL;
          end
        end
      end
      acs_pkg::ST_FLT_SUB: begin
        cmd.flt_sub = 1'b1;
        state_next  = acs_pkg::ST_FLT_MUL;
      end
      acs_pkg::ST_FLT_MUL: begin
        cmd.mul_flt = 1'b1;
        state_next  = acs_pkg::ST_FLT_SUM;
      end
      acs_pkg::ST_FLT_SUM: begin
        cmd.flt_sum = 1'b1;
        if (ch == acs_pkg::LAST_CH) begin
          state_next = acs_pkg::ST_FINISH;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = acs_pkg::ST_CAL_MUL;
        end
      end
      acs_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = acs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = acs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/acs_dp.sv -----
module acs_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  acs_pkg::cmd_t            cmd,
  output acs_pkg::status_t         status,
  input  logic                     cfg_we,
  input  acs_pkg::cfg_idx_t        cfg_index,
  input  logic [63:0]              cfg_data,
  input  logic [15:0]              raw_in [acs_pkg::NUM_IN],
  input  logic                     raw_valid,
  input  logic                     hw_fault,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       filt [acs_pkg::NUM_IN],
  output logic                     set_accepted
);

  logic [63:0]        cal [acs_pkg::NUM_IN];
  logic [16:0]        alpha;
  logic [15:0]        limit;
  logic [16:0]        alpha_wr;

  logic [15:0]        raw_q [acs_pkg::NUM_IN];
  logic               ok_q;
  logic               primed;
  logic signed [50:0] prod;
  logic signed [31:0] x_q;
  logic signed [32:0] d_q;
  logic signed [31:0] avg [acs_pkg::NUM_IN];

  logic               in_ok;
  logic [63:0]        cal_sel;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [50:0] cal_round;
  logic signed [31:0] cal_scaled;
  logic signed [32:0] cal_off_sum;
  logic signed [31:0] x;
  logic signed [50:0] flt_round;
  logic signed [35:0] flt_sum;
  logic signed [31:0] avg_upd;
  logic               out_free;

  // Configuration registers; the weight is stored already clamped to 1..65536
  always_comb begin
    alpha_wr = cfg_data[16:0];
    if (alpha_wr == 17'd0) begin
      alpha_wr = 17'd1;
    end else if (alpha_wr > acs_pkg::ALPHA_ONE) begin
      alpha_wr = acs_pkg::ALPHA_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < acs_pkg::NUM_IN; i++) begin
        cal[i] <= acs_pkg::CAL_RESET[i];
      end
      alpha <= acs_pkg::ALPHA_RESET;
      limit <= acs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        acs_pkg::CFG_CURRENT, acs_pkg::CFG_BUS, acs_pkg::CFG_PLANT, acs_pkg::CFG_TEMP: begin
          cal[cfg_index[1:0]] <= cfg_data;
        end
        acs_pkg::CFG_ALPHA: begin
          alpha <= alpha_wr;
        end
        acs_pkg::CFG_LIMIT: begin
          limit <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Set check
  always_comb begin
    in_ok = raw_valid & ~hw_fault;
    for (int i = 0; i < acs_pkg::NUM_IN; i++) begin
      if (raw_in[i] > limit) begin
        in_ok = 1'b0;
      end
    end
  end

  // Shared multiplier: raw*gain for calibration, diff*alpha for the filter
  assign cal_sel = cal[cmd.ch];
  assign mul_a   = cmd.mul_cal ? {cal_sel[63], cal_sel[63:32]} : d_q;
  assign mul_b   = cmd.mul_cal ? {2'b00, raw_q[cmd.ch]} : {1'b0, alpha};
  assign mul_p   = mul_a * mul_b;

  // Product with 24 fraction bits (Q8.24 gain) to Q16.16, round half up, then offset
  assign cal_round   = prod + 51'sd128;
  assign cal_scaled  = acs_pkg::sat32({{5{cal_round[50]}}, cal_round[50:8]});
  assign cal_off_sum = {cal_scaled[31], cal_scaled} +
                       {cal_sel[31], cal_sel[31:0]};
  assign x           = acs_pkg::sat32({{15{cal_off_sum[32]}}, cal_off_sum});

  // Moving average update
  assign flt_round = prod + 51'sd32768;
  assign flt_sum   = {flt_round[50], flt_round[50:16]} +
                     {{4{avg[cmd.ch][31]}}, avg[cmd.ch]};
  assign avg_upd   = acs_pkg::sat32({{12{flt_sum[35]}}, flt_sum});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < acs_pkg::NUM_IN; i++) begin
        raw_q[i] <= raw_in[i];
      end
    end
    if (cmd.mul_cal || cmd.mul_flt) begin
      prod <= mul_p;
    end
    if (cmd.cal_sum) begin
      x_q <= x;
    end
    if (cmd.flt_sub) begin
      d_q <= {x_q[31], x_q} - {avg[cmd.ch][31], avg[cmd.ch]};
    end
    if (cmd.load_avg) begin
      avg[cmd.ch] <= x;
    end else if (cmd.flt_sum) begin
      avg[cmd.ch] <= avg_upd;
    end
  end

  // Control flags and output register
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_q      <= 1'b0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        ok_q <= in_ok;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (ok_q) begin
          primed <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      set_accepted <= ok_q;
      for (int i = 0; i < acs_pkg::NUM_IN; i++) begin
        filt[i] <= (ok_q && i < acs_pkg::ACT_CH) ? avg[i] : 32'sd0;
      end
    end
  end

  assign status.in_ok    = in_ok;
  assign status.primed   = primed;
  assign status.out_free = out_free;

endmodule

// ----- rtl/core/adc_calibrate_smooth_core.sv -----
// Channel   Handshake            Payload
// ------    ---------            -------
// input     in_valid / in_stall  current_raw, bus_raw, plant_raw, temp_raw,
//                                raw_valid, hw_fault
// output    out_valid/out_stall  current_filtered, bus_filtered,
//                                plant_filtered, temp_filtered, set_accepted
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction at a time. A rejected set goes from accept straight to the
// finish step; the first accepted set loads each average directly after its
// calibration; later sets calibrate, subtract, multiply and sum per channel,
// CH active channels, sharing the single 33x18 multiplier for both products.
// Synchronous reset restores the register defaults and unprimes the filter.
// A stalled result holds in the output register; the next set is taken
// meanwhile and waits in the finish step until the result leaves.
module adc_calibrate_smooth_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        current_raw,
  input  logic [15:0]        bus_raw,
  input  logic [15:0]        plant_raw,
  input  logic [15:0]        temp_raw,
  input  logic               raw_valid,
  input  logic               hw_fault,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] current_filtered,
  output logic signed [31:0] bus_filtered,
  output logic signed [31:0] plant_filtered,
  output logic signed [31:0] temp_filtered,
  output logic               set_accepted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  acs_pkg::cmd_t      cmd;
  acs_pkg::status_t   status;
  logic [15:0]        raw_in [acs_pkg::NUM_IN];
  logic signed [31:0] filt   [acs_pkg::NUM_IN];

  // Registers are always writable; writes land only while idle by contract
  assign cfg_ready = 1'b1;

  assign raw_in[0] = current_raw;
  assign raw_in[1] = bus_raw;
  assign raw_in[2] = plant_raw;
  assign raw_in[3] = temp_raw;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  acs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_in       (raw_in),
    .raw_valid    (raw_valid),
    .hw_fault     (hw_fault),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filt         (filt),
    .set_accepted (set_accepted)
  );

  // Drive the result ports from the output register
  assign current_filtered = filt[0];
  assign bus_filtered     = filt[1];
  assign plant_filtered   = filt[2];
  assign temp_filtered    = filt[3];

endmodule

// ----- rtl/core/acs_chk.sv -----
module acs_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] current_filtered,
  input logic signed [31:0] bus_filtered,
  input logic signed [31:0] plant_filtered,
  input logic signed [31:0] temp_filtered,
  input logic               set_accepted
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_filtered) &&
      $stable(bus_filtered) && $stable(plant_filtered) &&
      $stable(temp_filtered) && $stable(set_accepted))
    else $error("stalled result changed");

  // A rejected set reports all zeros
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !set_accepted |-> current_filtered == 32'sd0 &&
      bus_filtered == 32'sd0 && plant_filtered == 32'sd0 && temp_filtered == 32'sd0)
    else $error("rejected set with nonzero values");

  // The block goes busy right after taking a set
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // A new result appears only from the busy finish step
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind adc_calibrate_smooth_core acs_chk u_acs_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .current_filtered (current_filtered),
  .bus_filtered     (bus_filtered),
  .plant_filtered   (plant_filtered),
  .temp_filtered    (temp_filtered),
  .set_accepted     (set_accepted)
);
